/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros shared by the arp cache rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ARPC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/arpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// shared constants, codes and types of the arp address cache
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int ENTRIES     = 8;
	localparam int SLOT_W      = $clog2(ENTRIES);

	localparam int PROTO_W     = 32;
	localparam int HW_W        = 48;
	localparam int STATUS_W    = 3;
	localparam int SLOT_OUT_W  = 3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic KIND_STORE  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_UPDATED  = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_FILLED   = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_REPLACED = STATUS_W'(2);
	localparam logic [STATUS_W-1:0] ST_HIT      = STATUS_W'(3);
	localparam logic [STATUS_W-1:0] ST_MISS     = STATUS_W'(4);

	// classified request as it sits in the queue
	typedef struct packed {
		logic               is_lookup;
		logic [PROTO_W-1:0] proto_addr;
		logic [HW_W-1:0]    hw_addr;
	} req_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic valid;
		req_t req;
	} queue_head_t;

	// one table entry as stored in the ram
	typedef struct packed {
		logic [PROTO_W-1:0] proto_addr;
		logic [HW_W-1:0]    hw_addr;
	} entry_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
	} front_stat_t;

endpackage

/* src/arpc_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_req_if
// request channel: store or lookup of an address mapping
// ----------------------------------------------------------------------------
interface arpc_req_if;

	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [arpc_pkg::PROTO_W-1:0] proto_addr;
	logic [arpc_pkg::HW_W-1:0]    hw_addr;

	modport source (output valid, output kind, output proto_addr, output hw_addr, input ready);
	modport sink (input valid, input kind, input proto_addr, input hw_addr, output ready);

endinterface

/* src/arpc_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_rsp_if
// response channel: outcome of one request
// ----------------------------------------------------------------------------
interface arpc_rsp_if;

	logic                            valid;
	logic                            ready;
	logic [arpc_pkg::STATUS_W-1:0]   status;
	logic [arpc_pkg::SLOT_OUT_W-1:0] slot;
	logic [arpc_pkg::HW_W-1:0]       found_hw_addr;

	modport source (output valid, output status, output slot, output found_hw_addr, input ready);
	modport sink (input valid, input status, input slot, input found_hw_addr, output ready);

endinterface

/* src/arpc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/arpc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_front
// accepts requests, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module arpc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	arpc_req_if.sink              req,
	output arpc_pkg::queue_head_t head,
	input  logic                  pop,
	output arpc_pkg::front_stat_t stat
);

	arpc_pkg::req_t                  q_mem_q [arpc_pkg::QUEUE_DEPTH];
	logic [arpc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [arpc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [arpc_pkg::QCNT_W-1:0]     count_q;
	arpc_pkg::req_t                  in_req;
	logic                            push;
	logic                            do_pop;
	logic                            full;

	assign full      = count_q == arpc_pkg::QCNT_W'(arpc_pkg::QUEUE_DEPTH);
	assign req.ready = !full;
	assign push      = req.valid && !full;
	assign do_pop    = pop && (count_q != '0);

	always_comb begin
		in_req.is_lookup  = req.kind == arpc_pkg::KIND_LOOKUP;
		in_req.proto_addr = req.proto_addr;
		in_req.hw_addr    = req.hw_addr;
	end

	assign head.valid = count_q != '0;
	assign head.req   = q_mem_q[rd_ptr_q];

	assign stat.count = count_q;
	assign stat.full  = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == arpc_pkg::QPTR_W'(arpc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + arpc_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == arpc_pkg::QPTR_W'(arpc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + arpc_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + arpc_pkg::QCNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - arpc_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= in_req;
		end
	end

endmodule

/* src/arpc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_back
// scans the table one entry per cycle, updates it and drives the response
// ----------------------------------------------------------------------------
module arpc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  arpc_pkg::queue_head_t head,
	output logic                  pop,
	arpc_rsp_if.source            rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_HOLD = 2'd2;

	logic [1:0]                          state_q;
	arpc_pkg::req_t                      cur_q;
	logic [arpc_pkg::SLOT_W-1:0]         k_q;
	logic                                empty_found_q;
	logic [arpc_pkg::SLOT_W-1:0]         empty_idx_q;
	logic [arpc_pkg::ENTRIES-1:0]        valid_q;

	logic [arpc_pkg::STATUS_W-1:0]       res_status_q;
	logic [arpc_pkg::SLOT_OUT_W-1:0]     res_slot_q;
	logic [arpc_pkg::HW_W-1:0]           res_found_q;

	logic                                out_valid_q;
	logic [arpc_pkg::STATUS_W-1:0]       out_status_q;
	logic [arpc_pkg::SLOT_OUT_W-1:0]     out_slot_q;
	logic [arpc_pkg::HW_W-1:0]           out_found_q;

	arpc_pkg::entry_t                    rd_entry;
	arpc_pkg::entry_t                    wr_entry;
	logic [arpc_pkg::SLOT_W-1:0]         rd_addr;
	logic                                hit;
	logic                                last;
	logic                                scan_done;
	logic                                out_free;
	logic                                load_dec;
	logic                                load_hold;
	logic                                has_empty;
	logic [arpc_pkg::SLOT_W-1:0]         empty_sel;

	logic                                dec_write;
	logic [arpc_pkg::SLOT_W-1:0]         dec_widx;
	logic [arpc_pkg::STATUS_W-1:0]       dec_status;
	logic [arpc_pkg::SLOT_OUT_W-1:0]     dec_slot;
	logic [arpc_pkg::HW_W-1:0]           dec_found;

	assign pop  = (state_q == S_IDLE) && head.valid;
	assign last = k_q == arpc_pkg::SLOT_W'(arpc_pkg::ENTRIES - 1);

	// read one ahead: entry k is compared while entry k+1 is fetched
	assign rd_addr = (state_q == S_SCAN && !last) ? k_q + arpc_pkg::SLOT_W'(1) : '0;

	assign hit       = valid_q[k_q] && (rd_entry.proto_addr == cur_q.proto_addr);
	assign scan_done = (state_q == S_SCAN) && (hit || last);
	assign out_free  = !out_valid_q || rsp.ready;
	assign load_dec  = scan_done && out_free;
	assign load_hold = (state_q == S_HOLD) && out_free;

	assign has_empty = empty_found_q || !valid_q[k_q];
	assign empty_sel = empty_found_q ? empty_idx_q : k_q;

	always_comb begin
		dec_write  = 1'b0;
		dec_widx   = '0;
		dec_status = arpc_pkg::ST_MISS;
		dec_slot   = '0;
		dec_found  = '0;
		if (cur_q.is_lookup) begin
			if (hit) begin
				dec_status = arpc_pkg::ST_HIT;
				dec_slot   = arpc_pkg::SLOT_OUT_W'(k_q);
				dec_found  = rd_entry.hw_addr;
			end
		end else if (hit) begin
			dec_write  = 1'b1;
			dec_widx   = k_q;
			dec_status = arpc_pkg::ST_UPDATED;
			dec_slot   = arpc_pkg::SLOT_OUT_W'(k_q);
		end else if (has_empty) begin
			dec_write  = 1'b1;
			dec_widx   = empty_sel;
			dec_status = arpc_pkg::ST_FILLED;
			dec_slot   = arpc_pkg::SLOT_OUT_W'(empty_sel);
		end else begin
			// table full: slot 0 is evicted
			dec_write  = 1'b1;
			dec_widx   = '0;
			dec_status = arpc_pkg::ST_REPLACED;
		end
	end

	always_comb begin
		wr_entry.proto_addr = cur_q.proto_addr;
		wr_entry.hw_addr    = cur_q.hw_addr;
	end

	arpc_ram #(
		.WIDTH($bits(arpc_pkg::entry_t)),
		.DEPTH(arpc_pkg::ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (scan_done && dec_write),
		.waddr (dec_widx),
		.wdata (wr_entry),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			k_q           <= '0;
			empty_found_q <= 1'b0;
			valid_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						state_q       <= S_SCAN;
						k_q           <= '0;
						empty_found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= out_free ? S_IDLE : S_HOLD;
					end else begin
						k_q <= k_q + arpc_pkg::SLOT_W'(1);
						if (!valid_q[k_q]) begin
							empty_found_q <= 1'b1;
						end
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (scan_done && dec_write) begin
				valid_q[dec_widx] <= 1'b1;
			end
			if (load_dec || load_hold) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.req;
		end
		// keep the first free slot seen during the scan
		if (state_q == S_SCAN && !scan_done && !valid_q[k_q] && !empty_found_q) begin
			empty_idx_q <= k_q;
		end
		if (scan_done) begin
			res_status_q <= dec_status;
			res_slot_q   <= dec_slot;
			res_found_q  <= dec_found;
		end
		if (load_dec) begin
			out_status_q <= dec_status;
			out_slot_q   <= dec_slot;
			out_found_q  <= dec_found;
		end else if (load_hold) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_found_q  <= res_found_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.slot          = out_slot_q;
	assign rsp.found_hw_addr = out_found_q;

endmodule

/* src/arp_address_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_address_cache
// fully associative ipv4 to hardware address cache with store and lookup
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                          request accepted when
//  req      in   kind, proto_addr, hw_addr        req.valid && req.ready
//  rsp      out  status, slot, found_hw_addr      rsp.valid && rsp.ready
//
// a request is popped from the queue, then the scan visits up to ENTRIES
// entries, one ram read per cycle, and stops at a match or the last entry.
// table writes happen in the last scan cycle, the response is registered.
// reset clears the valid bits at once, no clearing pass is needed.
// a two-deep queue takes requests while the scan runs or the response stalls.
//
`include "assert_macros.svh"

module arp_address_cache (
	input  logic        clk,
	input  logic        arst_n,
	arpc_req_if.sink    req,
	arpc_rsp_if.source  rsp
);

	arpc_pkg::queue_head_t head;
	arpc_pkg::front_stat_t front_stat;
	logic                  pop;

	arpc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.head   (head),
		.pop    (pop),
		.stat   (front_stat)
	);

	arpc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

	`ARPC_ASSERT_IMPL(a_miss_clean,
		rsp.valid && rsp.status == arpc_pkg::ST_MISS,
		rsp.slot == '0 && rsp.found_hw_addr == '0,
		"miss response carries slot or address")
	`ARPC_ASSERT_IMPL(a_store_no_addr,
		rsp.valid && rsp.status != arpc_pkg::ST_HIT,
		rsp.found_hw_addr == '0,
		"non-hit response carries an address")
	`ARPC_ASSERT_IMPL(a_replace_slot0,
		rsp.valid && rsp.status == arpc_pkg::ST_REPLACED,
		rsp.slot == '0,
		"replacement not in slot 0")
	`ARPC_ASSERT_NEXT(a_req_queued,
		req.valid && req.ready,
		front_stat.count != '0,
		"accepted request missing from queue")
	`ARPC_ASSERT_IMPL(a_full_stalls,
		front_stat.full,
		!req.ready,
		"full queue still takes requests")

endmodule
